// ===== hdl/mps_pkg.sv =====
// Package for the streaming max-pooling block: default sizes, register codes,
// configuration field widths and the depth of the result queue.
// No dependencies; every other file of the block except mps_ram uses it.
package mps_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_KERNEL = 8;
    localparam int DEF_DATA_WIDTH = 16;

    // Largest number of rows in one plane.
    localparam int ROW_LIMIT = 1024;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 11;
    localparam int KERNEL_W   = 4;

    // Register reset values.
    localparam int RST_KERNEL = 2;
    localparam int RST_ROWS   = 28;
    localparam int RST_COLS   = 28;

    // Result queue between the line-store stage and the output channel.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL = 2'd0,
        REG_ROWS   = 2'd1,
        REG_COLS   = 2'd2
    } t_reg_idx;

endpackage

// ===== hdl/mps_ifs.sv =====
// Channel interfaces of the max-pooling block: pixel input, pooled output and
// configuration write. Each carries valid, ready and its payload.
// Depends on mps_pkg.
interface mps_pixel_if #(parameter int DATA_WIDTH = mps_pkg::DEF_DATA_WIDTH);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mps_pool_if #(parameter int DATA_WIDTH = mps_pkg::DEF_DATA_WIDTH);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pooled_value;
    logic                         last_of_plane;
    modport source (output valid, output pooled_value, output last_of_plane, input ready);
    modport sink   (input valid, input pooled_value, input last_of_plane, output ready);
endinterface

interface mps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mps_pkg::CFG_IDX_W-1:0]      index;
    logic [mps_pkg::CFG_W-1:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mps_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters. No dependencies.
module mps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mps_out_fifo.sv =====
// Small result queue that decouples the pooling pipeline from the receiver.
// Holds OUT_DEPTH entries of WIDTH bits and reports its fill level.
// Depends on mps_pkg.
module mps_out_fifo #(
    parameter int WIDTH = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [WIDTH-1:0]              i_push_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [WIDTH-1:0]              o_data,
    output logic [mps_pkg::OUT_CNT_W-1:0] o_count
);
    import mps_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);

    logic [WIDTH-1:0]     r_buf [OUT_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count, n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    // Pointers wrap naturally since the depth is a power of two.
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hdl/max_pool_stream.sv =====
// Non-overlapping k-by-k max pooling over a raster stream of pixels.
// Depends on mps_pkg, the channel interfaces, mps_ram and mps_out_fifo.
//
// Usage:
//   i_pix carries one signed pixel per transfer, planes in raster order, one
//   plane after another. o_pool carries one pooled value per completed
//   window; last_of_plane marks the final window of a plane. Trailing rows
//   and columns that do not fill a window are consumed silently.
//   i_cfg writes kernel_size (index 0), plane_rows (1) and plane_cols (2);
//   any write also restarts the plane. Write only while the block is idle.
// Throughput: one pixel per cycle while the result queue has room. Stage 0
//   reads the line store of partial column maxima; stage 1 compares and writes
//   back, one read and one write of the single-port-per-direction RAM each cycle.
// Output: the result of the pixel that completes a window is registered in
//   stage 1, then pushed into the result queue, which offers it on o_pool.
// Stall: a four-entry result queue absorbs receiver stalls; i_pix.ready drops
//   only when the queue and the pipeline could not hold another result.
// Reset: registers return to k=2, 28 rows, 28 columns and the plane restarts.
//   The line store is not cleared; every entry is written by the first row of
//   a window before it is read.
module max_pool_stream #(
    parameter int MAX_COLS   = mps_pkg::DEF_MAX_COLS,
    parameter int MAX_KERNEL = mps_pkg::DEF_MAX_KERNEL,
    parameter int DATA_WIDTH = mps_pkg::DEF_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mps_pixel_if.sink i_pix,
    mps_cfg_if.sink   i_cfg,
    mps_pool_if.source o_pool
);
    import mps_pkg::*;

    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int PW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SW = CFG_W + 2;
    localparam int FW = DATA_WIDTH + 1;

    localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Clamp helpers for register writes.
    function automatic logic [KW-1:0] clamp_kernel(input logic [KERNEL_W-1:0] v);
        if (v == '0) begin
            return KW'(1);
        end else if (int'(v) > MAX_KERNEL) begin
            return KW'(MAX_KERNEL);
        end else begin
            return KW'(v);
        end
    endfunction

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int lim);
        if (v == '0) begin
            return CFG_W'(1);
        end else if (int'(v) > lim) begin
            return CFG_W'(lim);
        end else begin
            return v;
        end
    endfunction

    // Configuration registers, held in clamped form.
    logic [KW-1:0]    r_k;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;

    // Position state.
    logic [CFG_W-1:0] r_row_pos, n_row_pos;
    logic [CFG_W-1:0] r_col_pos, n_col_pos;
    logic [CFG_W-1:0] r_row_start, n_row_start;
    logic [CFG_W-1:0] r_col_start, n_col_start;
    logic [PW-1:0]    r_wrp, n_wrp;
    logic [PW-1:0]    r_wcp, n_wcp;
    logic [AW-1:0]    r_oci, n_oci;
    logic signed [DATA_WIDTH-1:0] r_rrm, n_rrm;

    // Stage 1: read-modify-write of the line store.
    logic                         r_s1_wr;
    logic                         r_s1_emit;
    logic                         r_s1_use_mem;
    logic                         r_s1_last;
    logic [AW-1:0]                r_s1_idx;
    logic signed [DATA_WIDTH-1:0] r_s1_m;

    logic                         cfg_wr;
    logic                         pix_acc;
    logic [KW-1:0]                k_m1;
    logic                         wcp_last;
    logic                         wrp_last;
    logic                         row_end;
    logic                         plane_end;
    logic [SW-1:0]                k_s;
    logic [SW-1:0]                row_fit;
    logic [SW-1:0]                col_fit;
    logic                         active;
    logic                         last_win;
    logic signed [DATA_WIDTH-1:0] px_max;
    logic                         mem_re;
    logic [DATA_WIDTH-1:0]        mem_rdata;
    logic signed [DATA_WIDTH-1:0] s1_max;
    logic [OUT_CNT_W-1:0]         q_count;
    logic [FW-1:0]                q_data;

    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    // Accept a pixel only when a result it may cause is sure to find room.
    assign i_pix.ready = ((OUT_CNT_W + 1)'(q_count) + (OUT_CNT_W + 1)'(r_s1_emit))
                         < (OUT_CNT_W + 1)'(OUT_DEPTH);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // Window geometry: a window is used when it fits entirely in the plane,
    // and it is the last one when the next window would not fit.
    always_comb begin
        k_m1      = r_k - KW'(1);
        wcp_last  = (KW'(r_wcp) == k_m1);
        wrp_last  = (KW'(r_wrp) == k_m1);
        row_end   = (r_col_pos == r_cols - CFG_W'(1));
        plane_end = (r_row_pos == r_rows - CFG_W'(1));
        k_s       = SW'(r_k);
        row_fit   = SW'(r_row_start) + k_s;
        col_fit   = SW'(r_col_start) + k_s;
        active    = (row_fit <= SW'(r_rows)) && (col_fit <= SW'(r_cols));
        last_win  = ((row_fit + k_s) > SW'(r_rows)) && ((col_fit + k_s) > SW'(r_cols));
        px_max    = ((r_wcp == '0) || (i_pix.pixel > r_rrm)) ? i_pix.pixel : r_rrm;
        mem_re    = pix_acc && active && wcp_last && (r_wrp != '0);
    end

    // Position advance for each accepted pixel.
    always_comb begin
        n_row_pos   = r_row_pos;
        n_col_pos   = r_col_pos;
        n_row_start = r_row_start;
        n_col_start = r_col_start;
        n_wrp       = r_wrp;
        n_wcp       = r_wcp;
        n_oci       = r_oci;
        n_rrm       = active ? px_max : r_rrm;
        if (wcp_last) begin
            n_wcp       = '0;
            n_oci       = r_oci + AW'(1);
            n_col_start = r_col_pos + CFG_W'(1);
        end else begin
            n_wcp = r_wcp + PW'(1);
        end
        n_col_pos = r_col_pos + CFG_W'(1);
        if (row_end) begin
            n_col_pos   = '0;
            n_col_start = '0;
            n_wcp       = '0;
            n_oci       = '0;
            n_rrm       = MOST_NEG;
            if (wrp_last) begin
                n_wrp       = '0;
                n_row_start = r_row_pos + CFG_W'(1);
            end else begin
                n_wrp = r_wrp + PW'(1);
            end
            n_row_pos = r_row_pos + CFG_W'(1);
            if (plane_end) begin
                n_row_pos   = '0;
                n_row_start = '0;
                n_wrp       = '0;
            end
        end
    end

    // Configuration registers and position state; a register write restarts
    // the plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= clamp_kernel(KERNEL_W'(RST_KERNEL));
            r_rows      <= clamp_size(CFG_W'(RST_ROWS), ROW_LIMIT);
            r_cols      <= clamp_size(CFG_W'(RST_COLS), MAX_COLS);
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_row_start <= '0;
            r_col_start <= '0;
            r_wrp       <= '0;
            r_wcp       <= '0;
            r_oci       <= '0;
            r_rrm       <= MOST_NEG;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                REG_KERNEL: r_k    <= clamp_kernel(i_cfg.data[KERNEL_W-1:0]);
                REG_ROWS:   r_rows <= clamp_size(i_cfg.data, ROW_LIMIT);
                REG_COLS:   r_cols <= clamp_size(i_cfg.data, MAX_COLS);
                default: begin
                end
            endcase
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_row_start <= '0;
            r_col_start <= '0;
            r_wrp       <= '0;
            r_wcp       <= '0;
            r_oci       <= '0;
            r_rrm       <= MOST_NEG;
        end else if (pix_acc) begin
            r_row_pos   <= n_row_pos;
            r_col_pos   <= n_col_pos;
            r_row_start <= n_row_start;
            r_col_start <= n_col_start;
            r_wrp       <= n_wrp;
            r_wcp       <= n_wcp;
            r_oci       <= n_oci;
            r_rrm       <= n_rrm;
        end
    end

    // Stage 1 control. The same line-store entry is touched again only a
    // full row later (at least two transfers), so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_wr   <= 1'b0;
            r_s1_emit <= 1'b0;
        end else begin
            r_s1_wr   <= pix_acc && active && wcp_last;
            r_s1_emit <= pix_acc && active && wcp_last && wrp_last;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_use_mem <= (r_wrp != '0);
            r_s1_last    <= last_win;
            r_s1_idx     <= r_oci;
            r_s1_m       <= px_max;
        end
    end

    // Line store of partial column maxima.
    mps_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_wr),
        .i_waddr (r_s1_idx),
        .i_wdata (s1_max),
        .i_re    (mem_re),
        .i_raddr (r_oci),
        .o_rdata (mem_rdata)
    );

    // Merge the row maximum with the maxima of earlier window rows.
    assign s1_max = (r_s1_use_mem && ($signed(mem_rdata) > r_s1_m)) ?
                    $signed(mem_rdata) : r_s1_m;

    // Result queue toward the output channel.
    mps_out_fifo #(
        .WIDTH (FW)
    ) u_out_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_emit),
        .i_push_data ({r_s1_last, s1_max}),
        .o_valid     (o_pool.valid),
        .i_ready     (o_pool.ready),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    assign o_pool.pooled_value  = $signed(q_data[DATA_WIDTH-1:0]);
    assign o_pool.last_of_plane = q_data[DATA_WIDTH];

endmodule

// ===== tb/tb_max_pool_stream.sv =====
// Self-checking testbench for max_pool_stream: pixel streams under many window and plane
// sizes, each pooled result compared against a cycle-free model of the pooling windows.
// Depends on mps_pkg, the channel interfaces in mps_ifs and the max_pool_stream top level.
`timescale 1ns / 100ps

module tb_max_pool_stream;
    import mps_pkg::*;

    localparam int DW           = DEF_DATA_WIDTH;
    localparam int MAX_COLS     = DEF_MAX_COLS;
    localparam int MAX_KERNEL   = DEF_MAX_KERNEL;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 150;
    localparam int SQUEEZE_LEN  = 150;

    // The one register index that maps to no register; a write there only restarts the plane.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [DW-1:0] PIX_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] PIX_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct {
        logic signed [DW-1:0] value;
        logic                 last;
    } t_pooled;

    // Tracks window maxima the way the block should and holds the pooled results still due.
    class window_max_tracker;
        logic [KERNEL_W-1:0]  kernel_reg;
        logic [CFG_W-1:0]     rows_reg;
        logic [CFG_W-1:0]     cols_reg;
        int unsigned          row_pos;
        int unsigned          col_pos;
        int unsigned          row_phase;
        int unsigned          col_phase;
        int unsigned          out_col;
        logic signed [DW-1:0] row_max;
        logic signed [DW-1:0] col_max [MAX_COLS];
        t_pooled              expected_windows[$];
        int                   errors;

        function new();
            kernel_reg = RST_KERNEL;
            rows_reg   = RST_ROWS;
            cols_reg   = RST_COLS;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            row_pos   = 0;
            col_pos   = 0;
            row_phase = 0;
            col_phase = 0;
            out_col   = 0;
            row_max   = PIX_MIN;
        endfunction

        // Zero acts as one and anything above the limit saturates.
        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        // Every write, whatever the index, restarts the plane.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (t_reg_idx'(idx))
                REG_KERNEL: kernel_reg = val[KERNEL_W-1:0];
                REG_ROWS:   rows_reg   = val;
                REG_COLS:   cols_reg   = val;
                default:    ;
            endcase
            restart();
        endfunction

        function void take_pixel(logic signed [DW-1:0] px);
            int unsigned          k;
            int unsigned          rows;
            int unsigned          cols;
            int unsigned          out_cols;
            int unsigned          rows_used;
            logic signed [DW-1:0] m;
            t_pooled              res;
            k         = clamp_size(kernel_reg, MAX_KERNEL);
            rows      = clamp_size(rows_reg, ROW_LIMIT);
            cols      = clamp_size(cols_reg, MAX_COLS);
            out_cols  = cols / k;
            rows_used = (rows / k) * k;

            // Only pixels inside a whole window take part.
            if (row_pos < rows_used && out_col < out_cols) begin
                if (col_phase == 0 || px > row_max) row_max = px;
                if (col_phase + 1 >= k) begin
                    m = row_max;
                    if (row_phase != 0 && col_max[out_col] > m) m = col_max[out_col];
                    col_max[out_col] = m;
                    if (row_phase + 1 >= k) begin
                        res.value = m;
                        res.last  = (row_pos + 1 == rows_used) && (out_col + 1 == out_cols);
                        expected_windows.push_back(res);
                    end
                end
            end

            // Step through the plane in raster order.
            col_phase++;
            if (col_phase >= k) begin
                col_phase = 0;
                out_col++;
            end
            col_pos++;
            if (col_pos >= cols) begin
                col_pos   = 0;
                col_phase = 0;
                out_col   = 0;
                row_max   = PIX_MIN;
                row_phase++;
                if (row_phase >= k) row_phase = 0;
                row_pos++;
                if (row_pos >= rows) begin
                    row_pos   = 0;
                    row_phase = 0;
                end
            end
        endfunction

        function void match_result(logic signed [DW-1:0] value, logic last);
            t_pooled exp_res;
            if (expected_windows.size() == 0) begin
                $error("unexpected result: pooled_value=%0d last_of_plane=%0b", value, last);
                errors++;
                return;
            end
            exp_res = expected_windows.pop_front();
            if (value !== exp_res.value) begin
                $error("pooled_value mismatch: expected %0d, actual %0d", exp_res.value, value);
                errors++;
            end
            if (last !== exp_res.last) begin
                $error("last_of_plane mismatch: expected %0b, actual %0b", exp_res.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mps_pixel_if #(.DATA_WIDTH(DW)) pix_if ();
    mps_cfg_if                      cfg_if ();
    mps_pool_if  #(.DATA_WIDTH(DW)) pool_if ();

    max_pool_stream #(
        .MAX_COLS  (MAX_COLS),
        .MAX_KERNEL(MAX_KERNEL),
        .DATA_WIDTH(DW)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if),
        .i_cfg  (cfg_if),
        .o_pool (pool_if)
    );

    window_max_tracker tracker;
    int                items_sent;
    int                results_seen;
    int                cycle_count;
    int                hold_left;
    logic              squeeze_req;
    bit                squeeze_done;

    // Clock generation.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_max_pool_stream failed");
            $finish;
        end
    end

    // Result side: check each transfer, then decide ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pool_if.valid && pool_if.ready) begin
            tracker.match_result(pool_if.pooled_value, pool_if.last_of_plane);
            results_seen++;
        end
        if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_left    = SQUEEZE_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            pool_if.ready <= 1'b0;
        end else if (results_seen >= 60 && results_seen < 260) begin
            pool_if.ready <= 1'b1;
        end else begin
            pool_if.ready <= ($urandom_range(99) >= 9);
        end
    end

    function automatic bit sender_idles();
        if (items_sent >= 300 && items_sent < 500) return 1'b0;
        return $urandom_range(99) < 9;
    endfunction

    // Mostly full-range values, with extremes and a narrow band that forces ties.
    function automatic logic signed [DW-1:0] next_pixel();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 7) return DW'($urandom);
        if (sel == 7) return ($urandom_range(1) != 0) ? PIX_MAX : PIX_MIN;
        return DW'($signed($urandom_range(7)) - 4);
    endfunction

    task automatic send_pixel(input logic signed [DW-1:0] px);
        while (sender_idles()) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge i_clk); while (!pix_if.ready);
        tracker.take_pixel(px);
        items_sent++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_pixel(next_pixel());
    endtask

    // Stop sending, let every expected result arrive, then let the pipeline settle.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                             input bit last_write);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.write_reg(idx, val);
        if (last_write) cfg_if.valid <= 1'b0;
    endtask

    // All three registers, starting at a random one.
    task automatic configure(input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] rows,
                             input logic [CFG_W-1:0] cols);
        int unsigned          first;
        int unsigned          idx;
        logic [CFG_W-1:0] vals [3];
        vals[0] = k;
        vals[1] = rows;
        vals[2] = cols;
        first   = $urandom_range(2);
        for (int j = 0; j < 3; j++) begin
            idx = (first + j) % 3;
            write_cfg(CFG_IDX_W'(idx), vals[idx], j == 2);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] rows,
                             input logic [CFG_W-1:0] cols, input int n);
        configure(k, rows, cols);
        send_random(n);
        wait_idle();
    endtask

    // Main sequence.
    initial begin
        int unsigned      sel;
        int unsigned      keff;
        int unsigned      rows;
        int unsigned      cols;
        int unsigned      plane;
        int               n;
        int               rand_items;
        logic [CFG_W-1:0] kdata;

        i_rst_n        = 1'b0;
        pix_if.valid   = 1'b0;
        pix_if.pixel   = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        pool_if.ready  = 1'b0;
        squeeze_req    = 1'b0;
        squeeze_done   = 1'b0;
        hold_left      = 0;
        items_sent     = 0;
        results_seen   = 0;
        cycle_count    = 0;
        rand_items     = 0;
        tracker        = new();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two rows under the reset configuration: k=2 over a 28-column plane.
        send_random(2 * RST_COLS);
        wait_idle();

        // One 2x2 window holding both extremes; upper kernel data bits are ignored.
        configure(11'h7F2, 11'd2, 11'd2);
        send_pixel(PIX_MIN);
        send_pixel(PIX_MAX);
        send_pixel('0);
        send_pixel(-16'sd1);
        // A window of nothing but the most negative value.
        repeat (4) send_pixel(PIX_MIN);
        wait_idle();

        // Zero kernel and zero sizes all act as one.
        configure(11'd0, 11'd0, 11'd0);
        send_pixel(16'sd12345);
        send_pixel(-16'sd1);
        wait_idle();

        // Kernel above the limit, and still larger than the plane: nothing comes out.
        configure(11'd15, 11'd3, 11'd3);
        send_random(4);
        wait_idle();

        // A write to the unused index restarts a plane left half done.
        configure(11'd2, 11'd2, 11'd4);
        send_random(3);
        wait_idle();
        write_cfg(REG_SPARE, 11'd0, 1'b1);
        send_random(8);
        wait_idle();

        // Random window and plane sizes, mostly whole planes.
        while (rand_items < RANDOM_ITEMS) begin
            sel = $urandom_range(9);
            if (sel < 6)       keff = $urandom_range(1, 4);
            else if (sel < 8)  keff = $urandom_range(5, MAX_KERNEL);
            else if (sel == 8) keff = 0;
            else               keff = $urandom_range(MAX_KERNEL + 1, 15);
            kdata = {(CFG_W - KERNEL_W)'($urandom), KERNEL_W'(keff)};
            keff  = tracker.clamp_size(keff, MAX_KERNEL);

            if ($urandom_range(9) == 0) rows = $urandom_range(0, keff);
            else if (keff <= 4) rows = $urandom_range(1, 2) * keff + $urandom_range(0, keff - 1);
            else rows = keff + $urandom_range(0, keff - 1);
            if ($urandom_range(9) == 0) cols = $urandom_range(0, keff);
            else if (keff <= 4) cols = $urandom_range(1, 2) * keff + $urandom_range(0, keff - 1);
            else cols = keff + $urandom_range(0, keff - 1);

            plane = tracker.clamp_size(rows, ROW_LIMIT) * tracker.clamp_size(cols, MAX_COLS);
            n = (plane > 60) ? plane : plane * $urandom_range(1, 3);
            // Now and then a plane is cut short by the next configuration.
            if ($urandom_range(4) == 0) n += $urandom_range(1, 2 * keff);
            run_phase(kdata, CFG_W'(rows), CFG_W'(cols), n);
            rand_items += n;
        end

        // Every pixel yields a result while the receiver holds off, so the block fills up.
        configure(11'd1, 11'd4, 11'd16);
        squeeze_req <= 1'b1;
        send_random(64);
        wait_idle();

        // Largest kernel: one full window and trailing columns.
        run_phase(11'd8, 11'd8, 11'd12, 96);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_max_pool_stream passed");
        end else begin
            $display("tb_max_pool_stream failed");
        end
        $finish;
    end

endmodule
